// ===== rtl/core/vpt_pkg.sv =====
// shared types, constants and helpers for the vertex perspective transform
// depends on nothing; imported by every module of the block but vpt_div
package vpt_pkg;

  localparam int COORD_WIDTH        = 24;
  localparam int COEF_FRACTION_BITS = 14;
  localparam int COEF_WIDTH         = COEF_FRACTION_BITS + 2;
  localparam int ROW_WIDTH          = 3 * COEF_WIDTH;
  localparam int NORM_WIDTH         = 16;
  localparam int NORM_FRAC          = 14;
  localparam int HALF_WIDTH         = 16;
  localparam int DEPTH_SCALE_WIDTH  = 32;
  localparam int DEPTH_SCALE_FRAC   = 16;
  localparam int DEVICE_SHIFT       = 6;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  =
      (ROW_WIDTH > 2 * COORD_WIDTH) ?
      ((ROW_WIDTH > DEPTH_SCALE_WIDTH) ? ROW_WIDTH : DEPTH_SCALE_WIDTH) :
      ((2 * COORD_WIDTH > DEPTH_SCALE_WIDTH) ? 2 * COORD_WIDTH : DEPTH_SCALE_WIDTH);

  // view accumulator: three products plus shifted translation plus rounding
  localparam int PROD_WIDTH = COEF_WIDTH + COORD_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;

  // perspective gains in Q.14: 0.375 and 0.5
  localparam int X_GAIN = 3 << (NORM_FRAC - 3);
  localparam int Y_GAIN = 1 << (NORM_FRAC - 1);

  // divider sizing
  localparam int NUM_WIDTH  = DEPTH_SCALE_WIDTH + COORD_WIDTH + 1;
  localparam int DEN_WIDTH  = COORD_WIDTH + 2;
  localparam int QUOT_WIDTH = 31;
  localparam int DIV_LATENCY = QUOT_WIDTH + 1;
  localparam int DEV_PROD_WIDTH = QUOT_WIDTH + 2 + HALF_WIDTH + 1;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_TRANS_XY,
    REG_TRANS_Z,
    REG_DEPTH_SCALE,
    REG_DEPTH_OFFSET,
    REG_HALF_EXTENT
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_WIDTH-1:0]             rot_x;
    logic [ROW_WIDTH-1:0]             rot_y;
    logic [ROW_WIDTH-1:0]             rot_z;
    logic [2*COORD_WIDTH-1:0]         trans_xy;
    logic signed [COORD_WIDTH-1:0]    trans_z;
    logic signed [DEPTH_SCALE_WIDTH-1:0] depth_scale;
    logic signed [COORD_WIDTH-1:0]    depth_offset;
    logic [2*HALF_WIDTH-1:0]          half_extent;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] model_x;
    logic signed [COORD_WIDTH-1:0] model_y;
    logic signed [COORD_WIDTH-1:0] model_z;
    logic                          visible;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] view_x;
    logic signed [COORD_WIDTH-1:0] view_y;
    logic signed [COORD_WIDTH-1:0] view_z;
    logic signed [COORD_WIDTH-1:0] device_x;
    logic signed [COORD_WIDTH-1:0] device_y;
    logic signed [NORM_WIDTH-1:0]  norm_z;
    logic                          projected;
    logic                          zero_depth;
  } result_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          visible;
  } view_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      sat_coord = hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_WIDTH-1:0];
    end else begin
      sat_coord = v[COORD_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [NORM_WIDTH-1:0] sat_norm(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (NORM_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      sat_norm = hi[NORM_WIDTH-1:0];
    end else if (v < lo) begin
      sat_norm = lo[NORM_WIDTH-1:0];
    end else begin
      sat_norm = v[NORM_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/vertex_perspective_transform.sv =====
// top level: configuration registers, view transform and projection pipeline
// depends on vpt_pkg, vpt_view, vpt_project (and vpt_div below it)
//
// usage:
//   input channel: drive vertex and pulse start; a word is taken at every edge
//   with start high and busy low. busy is always low, so a new vertex can be
//   given in every cycle.
//   output channel: done is high for one cycle with the result word on result.
//   the receiver cannot hold results off; every accepted vertex yields exactly
//   one result, in order.
//   path: a vertex passes the view products and sums, numerator setup, the
//   pipelined dividers, then device scaling and the output register, before
//   its done cycle.
//   throughput: one vertex per cycle, set by the fully pipelined dividers.
//   configuration: cfg_we, cfg_index and cfg_data write one register per
//   cycle; write only while no vertex is in flight.
//   reset: rst (synchronous) loads the default view matrix and depth constants
//   and drops every word in flight; no done follows for them.
module vertex_perspective_transform (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  vpt_pkg::vertex_t                      vertex,
  output logic                                  done,
  output vpt_pkg::result_t                      result,
  input  logic                                  cfg_we,
  input  logic [vpt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [vpt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import vpt_pkg::*;

  cfg_t  cfg;
  logic  view_valid;
  view_t view;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_x        <= ROW_WIDTH'(1) << COEF_FRACTION_BITS;
      cfg.rot_y        <= ROW_WIDTH'(1) << (COEF_FRACTION_BITS + COEF_WIDTH);
      cfg.rot_z        <= ROW_WIDTH'(1) << (COEF_FRACTION_BITS + 2 * COEF_WIDTH);
      cfg.trans_xy     <= '0;
      cfg.trans_z      <= '0;
      cfg.depth_scale  <= DEPTH_SCALE_WIDTH'(68985);
      cfg.depth_offset <= COORD_WIDTH'(-2695);
      cfg.half_extent  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROT_X:        cfg.rot_x        <= cfg_data[ROW_WIDTH-1:0];
        REG_ROT_Y:        cfg.rot_y        <= cfg_data[ROW_WIDTH-1:0];
        REG_ROT_Z:        cfg.rot_z        <= cfg_data[ROW_WIDTH-1:0];
        REG_TRANS_XY:     cfg.trans_xy     <= cfg_data[2*COORD_WIDTH-1:0];
        REG_TRANS_Z:      cfg.trans_z      <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_DEPTH_SCALE:  cfg.depth_scale  <= $signed(cfg_data[DEPTH_SCALE_WIDTH-1:0]);
        REG_DEPTH_OFFSET: cfg.depth_offset <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_HALF_EXTENT:  cfg.half_extent  <= cfg_data[2*HALF_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  vpt_view u_view (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .vertex    (vertex),
    .cfg       (cfg),
    .out_valid (view_valid),
    .view      (view)
  );

  vpt_project u_project (
    .clk      (clk),
    .rst      (rst),
    .in_valid (view_valid),
    .view     (view),
    .cfg      (cfg),
    .done     (done),
    .result   (result)
  );

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.projected && result.zero_depth))
    else $error("projected and zero_depth both set");

  a_unprojected_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.projected |->
      result.device_x == '0 && result.device_y == '0 && result.norm_z == '0)
    else $error("device fields nonzero on an unprojected word");

  a_zero_depth_view: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_depth |-> result.view_z == '0)
    else $error("zero_depth with nonzero view z");

  a_projected_depth: assert property (@(posedge clk) disable iff (rst)
    done && result.projected |-> result.view_z != '0)
    else $error("projected word with zero view z");

endmodule

// ===== rtl/core/vpt_view.sv =====
// affine view transform: nine coefficient products, then row sums with rounding
// depends on vpt_pkg
module vpt_view (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  vpt_pkg::vertex_t vertex,
  input  vpt_pkg::cfg_t    cfg,
  output logic             out_valid,
  output vpt_pkg::view_t   view
);
  import vpt_pkg::*;

  logic [ROW_WIDTH-1:0]          rows [3];
  logic signed [COORD_WIDTH-1:0] trans [3];
  logic signed [COORD_WIDTH-1:0] model [3];

  logic signed [PROD_WIDTH-1:0]  prod [3][3];
  logic signed [COORD_WIDTH-1:0] trans_r [3];
  logic                          visible_r;
  logic                          prod_valid;

  logic signed [ACC_WIDTH-1:0]   acc [3];
  logic signed [ACC_WIDTH-1:0]   rounded [3];

  assign rows[0]  = cfg.rot_x;
  assign rows[1]  = cfg.rot_y;
  assign rows[2]  = cfg.rot_z;
  assign trans[0] = $signed(cfg.trans_xy[COORD_WIDTH-1:0]);
  assign trans[1] = $signed(cfg.trans_xy[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign trans[2] = cfg.trans_z;
  assign model[0] = vertex.model_x;
  assign model[1] = vertex.model_y;
  assign model[2] = vertex.model_z;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= $signed(rows[r][k*COEF_WIDTH +: COEF_WIDTH]) * model[k];
      end
      trans_r[r] <= trans[r];
    end
    visible_r <= vertex.visible;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  // round half up, then clamp to the coordinate range
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = ACC_WIDTH'(prod[r][0]) + ACC_WIDTH'(prod[r][1]) + ACC_WIDTH'(prod[r][2])
             + (ACC_WIDTH'(trans_r[r]) <<< COEF_FRACTION_BITS);
      rounded[r] = (acc[r] + (ACC_WIDTH'(1) <<< (COEF_FRACTION_BITS - 1)))
                   >>> COEF_FRACTION_BITS;
    end
  end

  always_ff @(posedge clk) begin
    view.x       <= sat_coord(64'(rounded[0]));
    view.y       <= sat_coord(64'(rounded[1]));
    view.z       <= sat_coord(64'(rounded[2]));
    view.visible <= visible_r;
  end

endmodule

// ===== rtl/core/vpt_div.sv =====
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on nothing; quotient saturates to all ones when it would not fit
module vpt_div #(
  parameter int NUM_W  = 57,
  parameter int DEN_W  = 26,
  parameter int QUOT_W = 31
) (
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUOT_W-1:0] quot
);

  localparam int CMP_W = (NUM_W > DEN_W + QUOT_W) ? NUM_W : DEN_W + QUOT_W;

  logic [NUM_W-1:0]  rem [QUOT_W+1];
  logic [DEN_W-1:0]  dv  [QUOT_W];
  logic [QUOT_W-1:0] qv  [QUOT_W+1];
  logic              ovf [QUOT_W+1];

  // entry: flag a quotient too large for the stages
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    qv[0]  <= '0;
    ovf[0] <= CMP_W'(num) >= (CMP_W'(den) << QUOT_W);
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    localparam int B = QUOT_W - 1 - j;
    logic [CMP_W-1:0] shifted;
    logic             take;

    assign shifted = CMP_W'(dv[j]) << B;
    assign take    = CMP_W'(rem[j]) >= shifted;

    always_ff @(posedge clk) begin
      rem[j+1] <= take ? NUM_W'(CMP_W'(rem[j]) - shifted) : rem[j];
      qv[j+1]  <= qv[j] | (take ? (QUOT_W'(1) << B) : '0);
      ovf[j+1] <= ovf[j];
    end

    if (j < QUOT_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        dv[j+1] <= dv[j];
      end
    end
  end

  assign quot = ovf[QUOT_W] ? '1 : qv[QUOT_W];

endmodule

// ===== rtl/core/vpt_project.sv =====
// perspective divide, depth mapping and device scaling behind the view stage
// depends on vpt_pkg and vpt_div
module vpt_project (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  vpt_pkg::view_t   view,
  input  vpt_pkg::cfg_t    cfg,
  output logic             done,
  output vpt_pkg::result_t result
);
  import vpt_pkg::*;

  typedef struct packed {
    view_t view;
    logic  neg_x;
    logic  neg_y;
    logic  neg_z;
  } side_t;

  // numerator setup
  logic                                        p1_valid;
  view_t                                       p1_view;
  logic signed [NUM_WIDTH-1:0]                 num_x;
  logic signed [NUM_WIDTH-1:0]                 num_y;
  logic signed [DEPTH_SCALE_WIDTH+COORD_WIDTH-1:0] prod_z;

  logic signed [NUM_WIDTH-1:0] num_z;
  logic [COORD_WIDTH-1:0]      z_mag;

  logic [NUM_WIDTH-1:0]  mag_x;
  logic [NUM_WIDTH-1:0]  mag_y;
  logic [NUM_WIDTH-1:0]  mag_z;
  logic [DEN_WIDTH-1:0]  den_xy;
  logic [DEN_WIDTH-1:0]  den_z;

  side_t side       [DIV_LATENCY+1];
  logic  side_valid [DIV_LATENCY+1];

  logic [QUOT_WIDTH-1:0] quot_x;
  logic [QUOT_WIDTH-1:0] quot_y;
  logic [QUOT_WIDTH-1:0] quot_z;

  logic signed [QUOT_WIDTH:0]   n_x;
  logic signed [QUOT_WIDTH:0]   n_y;
  logic signed [QUOT_WIDTH:0]   n_z;
  logic signed [QUOT_WIDTH+1:0] bias_x;
  logic signed [QUOT_WIDTH+1:0] bias_y;

  logic                               p3_valid;
  view_t                              p3_view;
  logic                               p3_projected;
  logic signed [DEV_PROD_WIDTH-1:0]   dev_x;
  logic signed [DEV_PROD_WIDTH-1:0]   dev_y;
  logic signed [NORM_WIDTH-1:0]       p3_norm_z;

  logic signed [DEV_PROD_WIDTH-1:0]   shift_x;
  logic signed [DEV_PROD_WIDTH-1:0]   shift_y;

  always_ff @(posedge clk) begin
    p1_view <= view;
    num_x   <= $signed(NUM_WIDTH'(view.x)) * $signed(NUM_WIDTH'(X_GAIN));
    num_y   <= $signed(NUM_WIDTH'(view.y)) * $signed(NUM_WIDTH'(Y_GAIN));
    prod_z  <= cfg.depth_scale * view.z;
  end

  assign num_z = NUM_WIDTH'(prod_z) + (NUM_WIDTH'(cfg.depth_offset) <<< DEPTH_SCALE_FRAC);
  assign z_mag = p1_view.z[COORD_WIDTH-1] ? COORD_WIDTH'(-p1_view.z) : COORD_WIDTH'(p1_view.z);

  // magnitudes into the dividers, signs ride alongside
  always_ff @(posedge clk) begin
    mag_x  <= num_x[NUM_WIDTH-1] ? NUM_WIDTH'(-num_x) : NUM_WIDTH'(num_x);
    mag_y  <= num_y[NUM_WIDTH-1] ? NUM_WIDTH'(-num_y) : NUM_WIDTH'(num_y);
    mag_z  <= num_z[NUM_WIDTH-1] ? NUM_WIDTH'(-num_z) : NUM_WIDTH'(num_z);
    den_xy <= DEN_WIDTH'(z_mag);
    den_z  <= DEN_WIDTH'(z_mag) << 2;
    side[0].view  <= p1_view;
    side[0].neg_x <= num_x[NUM_WIDTH-1] ^ p1_view.z[COORD_WIDTH-1];
    side[0].neg_y <= num_y[NUM_WIDTH-1] ^ p1_view.z[COORD_WIDTH-1];
    side[0].neg_z <= num_z[NUM_WIDTH-1] ^ p1_view.z[COORD_WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      side_valid[0] <= 1'b0;
    end else begin
      p1_valid      <= in_valid;
      side_valid[0] <= p1_valid;
    end
  end

  for (genvar k = 0; k < DIV_LATENCY; k++) begin : g_side
    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side_valid[k+1] <= 1'b0;
      end else begin
        side_valid[k+1] <= side_valid[k];
      end
    end
  end

  vpt_div #(.NUM_W(NUM_WIDTH), .DEN_W(DEN_WIDTH), .QUOT_W(QUOT_WIDTH)) u_div_x (
    .clk  (clk),
    .num  (mag_x),
    .den  (den_xy),
    .quot (quot_x)
  );

  vpt_div #(.NUM_W(NUM_WIDTH), .DEN_W(DEN_WIDTH), .QUOT_W(QUOT_WIDTH)) u_div_y (
    .clk  (clk),
    .num  (mag_y),
    .den  (den_xy),
    .quot (quot_y)
  );

  vpt_div #(.NUM_W(NUM_WIDTH), .DEN_W(DEN_WIDTH), .QUOT_W(QUOT_WIDTH)) u_div_z (
    .clk  (clk),
    .num  (mag_z),
    .den  (den_z),
    .quot (quot_z)
  );

  // truncation toward zero: magnitude quotient with the sign reapplied
  always_comb begin
    n_x = side[DIV_LATENCY].neg_x ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
    n_y = side[DIV_LATENCY].neg_y ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
    n_z = side[DIV_LATENCY].neg_z ? -$signed({1'b0, quot_z}) : $signed({1'b0, quot_z});
    bias_x = (QUOT_WIDTH+2)'(n_x) + $signed((QUOT_WIDTH+2)'(1 << NORM_FRAC));
    bias_y = (QUOT_WIDTH+2)'(n_y) + $signed((QUOT_WIDTH+2)'(1 << NORM_FRAC));
  end

  always_ff @(posedge clk) begin
    p3_view      <= side[DIV_LATENCY].view;
    p3_projected <= side[DIV_LATENCY].view.visible && (side[DIV_LATENCY].view.z != '0);
    dev_x <= bias_x * $signed({1'b0, cfg.half_extent[HALF_WIDTH-1:0]});
    dev_y <= bias_y * $signed({1'b0, cfg.half_extent[2*HALF_WIDTH-1:HALF_WIDTH]});
    p3_norm_z <= sat_norm(64'(n_z));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      p3_valid <= side_valid[DIV_LATENCY];
      done     <= p3_valid;
    end
  end

  assign shift_x = (dev_x + DEV_PROD_WIDTH'(32)) >>> DEVICE_SHIFT;
  assign shift_y = (dev_y + DEV_PROD_WIDTH'(32)) >>> DEVICE_SHIFT;

  always_ff @(posedge clk) begin
    result.view_x     <= p3_view.x;
    result.view_y     <= p3_view.y;
    result.view_z     <= p3_view.z;
    result.device_x   <= p3_projected ? sat_coord(64'(shift_x)) : '0;
    result.device_y   <= p3_projected ? sat_coord(64'(shift_y)) : '0;
    result.norm_z     <= p3_projected ? p3_norm_z : '0;
    result.projected  <= p3_projected;
    result.zero_depth <= p3_view.visible && (p3_view.z == '0);
  end

endmodule
